>>> sv/pan_law_gain_calc_defines.svh
// assertion macros for the pan law gain calculator
`ifndef PAN_LAW_GAIN_CALC_DEFINES_SVH
`define PAN_LAW_GAIN_CALC_DEFINES_SVH
`ifndef SYNTH
// property that holds in every cycle out of reset
`define PLGC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition in one cycle implies a condition in the next
`define PLGC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define PLGC_ASSERT(label, clk, rst_n, prop, msg)
`define PLGC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> sv/plgc_pkg.sv
package plgc_pkg;

  // two taper lanes: left and right
  localparam int unsigned NUM_LANES = 2;
  localparam int unsigned LANE_L = 0;
  localparam int unsigned LANE_R = 1;

  // item modes
  typedef enum logic {
    CMD_MONO    = 1'b0,
    CMD_BALANCE = 1'b1
  } cmd_e;

  // fixed-point constants
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [15:0] PAN_FULL = 16'sd16384;
  localparam logic [15:0] TAPER_FULL  = 16'd32768;

  // horner divisors of the cosine series
  localparam int unsigned HORNER_STEPS = 7;
  localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{182, 132, 90, 56, 30, 12, 2};

  // square root: one result bit per cell
  localparam int unsigned SQRT_STEPS = 32;

  // data handed along the horner chain
  typedef struct packed {
    logic [15:0] v;
    logic [31:0] th2;
    logic [30:0] acc;
  } horner_t;
  typedef horner_t [NUM_LANES-1:0] horner_pair_t;

  // data handed along the square root chain
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } sqrt_t;
  typedef sqrt_t [NUM_LANES-1:0] sqrt_pair_t;

endpackage

>>> sv/pan_law_gain_calc.sv
// channel  | direction | fields                        | handshake
// input    | in        | cmd_i, pan_i                  | in_valid_i / in_stall_o
// output   | out       | gain_left_o, gain_right_o     | out_valid_o / out_stall_i
//
// one item per cycle sustained while the output does not stall; the path from accept
// to result runs through the 32-cell square-root chain, the seven two-stage
// horner cells of the cosine and five angle, product and output stages
// reset clears the valid bits only; no clearing pass
// a stalled output holds; upstream stages keep taking items into empty slots
`include "pan_law_gain_calc_defines.svh"
module pan_law_gain_calc #(
  parameter int unsigned GAIN_FRAC_BITS = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic signed [15:0] pan_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        gain_left_o,
  output logic [15:0]        gain_right_o
);
  import plgc_pkg::*;

  localparam int unsigned Shift = 31 - GAIN_FRAC_BITS;
  localparam logic [32:0] RoundHalf = 33'd1 << (Shift - 1);
  localparam logic [15:0] GainOne = 16'(1 << GAIN_FRAC_BITS);

  logic signed [15:0] pan_c;
  logic [15:0] pan_u, pan_mag, v_bal;
  logic [NUM_LANES-1:0][15:0] v_d;
  logic taper_valid, taper_stall, out_stall;
  logic [NUM_LANES-1:0][31:0] root;
  logic out_valid_q;
  logic [15:0] gain_left_q, gain_right_q;

  // clamp pan and pick the taper inputs of each side
  always_comb begin
    if (pan_i < -PAN_FULL) begin
      pan_c = -PAN_FULL;
    end else if (pan_i > PAN_FULL) begin
      pan_c = PAN_FULL;
    end else begin
      pan_c = pan_i;
    end
    pan_u   = 16'(pan_c) + 16'(PAN_FULL);
    pan_mag = pan_c[15] ? 16'(-pan_c) : 16'(pan_c);
    v_bal   = pan_mag << 1;
    case (cmd_e'(cmd_i))
      CMD_MONO: begin
        v_d[LANE_L] = pan_u;
        v_d[LANE_R] = TAPER_FULL - pan_u;
      end
      CMD_BALANCE: begin
        // louder side gets taper of zero, which is exactly one
        v_d[LANE_L] = (pan_c > 16'sd0) ? v_bal : 16'd0;
        v_d[LANE_R] = (pan_c < 16'sd0) ? v_bal : 16'd0;
      end
      default: begin
        v_d[LANE_L] = 16'd0;
        v_d[LANE_R] = 16'd0;
      end
    endcase
  end

  plgc_taper u_taper (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .stall_o(in_stall_o),
    .v_i    (v_d),
    .valid_o(taper_valid),
    .stall_i(taper_stall),
    .root_o (root)
  );

  assign out_stall   = out_valid_q & out_stall_i;
  assign taper_stall = out_stall;

  // output register with rounding to the gain format
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_stall) begin
      out_valid_q <= taper_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (taper_valid && !out_stall) begin
      gain_left_q  <= 16'(({1'b0, root[LANE_L]} + RoundHalf) >> Shift);
      gain_right_q <= 16'(({1'b0, root[LANE_R]} + RoundHalf) >> Shift);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gain_left_o  = gain_left_q;
  assign gain_right_o = gain_right_q;

  `PLGC_ASSERT(a_stall_cause, clk_i, rst_ni,
    in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without output stall")
  `PLGC_ASSERT(a_gain_max, clk_i, rst_ni,
    out_valid_o |-> ((GAIN_FRAC_BITS > 15) ||
      ((gain_left_o <= GainOne) && (gain_right_o <= GainOne))), "gain above one")

endmodule

>>> sv/plgc_horner_cell.sv
`include "pan_law_gain_calc_defines.svh"
module plgc_horner_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  plgc_pkg::horner_pair_t data_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output plgc_pkg::horner_pair_t data_o
);
  import plgc_pkg::*;

  localparam int unsigned K = HORNER_DIV[STEP];
  localparam int unsigned S = 32 + $clog2(K);
  localparam logic [32:0] MulC = 33'(((65'd1 << S) + 65'(K) - 65'd1) / 65'(K));
  localparam logic [63:0] RoundAdd = (64'd1 << 29) + (64'(K / 2) << 30);

  logic                 a_valid_q, a_stall;
  logic [NUM_LANES-1:0][15:0] a_v_q;
  logic [NUM_LANES-1:0][31:0] a_th2_q;
  logic [NUM_LANES-1:0][62:0] a_mul_q;
  logic                 b_valid_q, b_stall;
  horner_pair_t         b_d, b_q;

  assign b_stall = b_valid_q & stall_i;
  assign a_stall = a_valid_q & b_stall;
  assign stall_o = a_stall;

  // stage a: th2 * acc
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (!a_stall) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !a_stall) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        a_v_q[l]   <= data_i[l].v;
        a_th2_q[l] <= data_i[l].th2;
        a_mul_q[l] <= 63'(data_i[l].th2) * 63'(data_i[l].acc);
      end
    end
  end

  // stage b: round, divide by the constant via reciprocal, subtract from one
  always_comb begin
    logic [63:0] sum;
    logic [31:0] n;
    logic [64:0] qm;
    logic [31:0] q;
    for (int l = 0; l < NUM_LANES; l++) begin
      sum = 64'(a_mul_q[l]) + RoundAdd;
      n   = 32'(sum >> 30);
      qm  = 65'(n) * 65'(MulC);
      q   = 32'(qm >> S);
      b_d[l].v   = a_v_q[l];
      b_d[l].th2 = a_th2_q[l];
      if (q > {1'b0, Q30_ONE}) begin
        b_d[l].acc = '0;
      end else begin
        b_d[l].acc = 31'({1'b0, Q30_ONE} - q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (!b_stall) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && !b_stall) begin
      b_q <= b_d;
    end
  end

  assign valid_o = b_valid_q;
  assign data_o  = b_q;

  `PLGC_ASSERT(a_acc_max, clk_i, rst_ni, valid_o |-> ((data_o[LANE_L].acc <= Q30_ONE) && (data_o[LANE_R].acc <= Q30_ONE)), "horner acc above one")

endmodule

>>> sv/plgc_sqrt_cell.sv
module plgc_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  plgc_pkg::sqrt_pair_t data_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output plgc_pkg::sqrt_pair_t data_o
);
  import plgc_pkg::*;

  localparam logic [63:0] Bit = 64'd1 << (62 - 2 * STEP);

  logic       valid_q, stall;
  sqrt_pair_t data_d, data_q;

  assign stall   = valid_q & stall_i;
  assign stall_o = stall;

  // one restoring step: try the next result bit
  always_comb begin
    logic [63:0] trial;
    for (int l = 0; l < NUM_LANES; l++) begin
      trial = data_i[l].res + Bit;
      if (data_i[l].rem >= trial) begin
        data_d[l].rem = data_i[l].rem - trial;
        data_d[l].res = (data_i[l].res >> 1) + Bit;
      end else begin
        data_d[l].rem = data_i[l].rem;
        data_d[l].res = data_i[l].res >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> sv/plgc_taper.sv
`include "pan_law_gain_calc_defines.svh"
module plgc_taper (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   stall_o,
  input  logic [plgc_pkg::NUM_LANES-1:0][15:0]   v_i,
  output logic                                   valid_o,
  input  logic                                   stall_i,
  output logic [plgc_pkg::NUM_LANES-1:0][31:0]   root_o
);
  import plgc_pkg::*;

  logic s1_valid_q, s1_stall;
  logic s2_valid_q, s2_stall;
  logic s3_valid_q, s3_stall;
  logic sp_valid_q, sp_stall;
  logic [NUM_LANES-1:0][15:0] s1_v_q, s2_v_q;
  logic [NUM_LANES-1:0][46:0] s1_mul_q;
  logic [NUM_LANES-1:0][61:0] s2_sq_q;
  horner_pair_t s3_q;
  sqrt_pair_t   sp_q;

  logic         hv [HORNER_STEPS+1];
  logic         hs [HORNER_STEPS+1];
  horner_pair_t hd [HORNER_STEPS+1];
  logic         sv [SQRT_STEPS+1];
  logic         ss [SQRT_STEPS+1];
  sqrt_pair_t   sd [SQRT_STEPS+1];

  assign s1_stall = s1_valid_q & s2_stall;
  assign s2_stall = s2_valid_q & s3_stall;
  assign s3_stall = s3_valid_q & hs[0];
  assign sp_stall = sp_valid_q & ss[0];
  assign stall_o  = s1_stall;

  // valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      sp_valid_q <= 1'b0;
    end else begin
      if (!s1_stall) s1_valid_q <= valid_i;
      if (!s2_stall) s2_valid_q <= s1_valid_q;
      if (!s3_stall) s3_valid_q <= s2_valid_q;
      if (!sp_stall) sp_valid_q <= hv[HORNER_STEPS];
    end
  end

  // angle: v * pi/2
  always_ff @(posedge clk_i) begin
    if (valid_i && !s1_stall) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        s1_v_q[l]   <= v_i[l];
        s1_mul_q[l] <= 47'(v_i[l]) * 47'(HALF_PI_Q30);
      end
    end
  end

  // theta rounded, then squared
  always_ff @(posedge clk_i) begin
    logic [31:0] theta;
    if (s1_valid_q && !s2_stall) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        theta       = 32'((48'(s1_mul_q[l]) + 48'd16384) >> 15);
        s2_v_q[l]  <= s1_v_q[l];
        s2_sq_q[l] <= 62'(theta) * 62'(theta);
      end
    end
  end

  // th2 rounded, accumulator starts at one
  always_ff @(posedge clk_i) begin
    if (s2_valid_q && !s3_stall) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        s3_q[l].v   <= s2_v_q[l];
        s3_q[l].th2 <= 32'((63'(s2_sq_q[l]) + (63'd1 << 29)) >> 30);
        s3_q[l].acc <= Q30_ONE;
      end
    end
  end

  // horner chain for the cosine
  assign hv[0] = s3_valid_q;
  assign hd[0] = s3_q;
  assign hs[HORNER_STEPS] = sp_stall;

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
    plgc_horner_cell #(
      .STEP(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(hv[i]),
      .stall_o(hs[i]),
      .data_i (hd[i]),
      .valid_o(hv[i+1]),
      .stall_i(hs[i+1]),
      .data_o (hd[i+1])
    );
  end

  // product (1 - x) * cos, scaled for the root
  always_ff @(posedge clk_i) begin
    logic [16:0] span;
    logic [47:0] prod;
    if (hv[HORNER_STEPS] && !sp_stall) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        span        = 17'(TAPER_FULL) - 17'(hd[HORNER_STEPS][l].v);
        prod        = 48'(span) * 48'(hd[HORNER_STEPS][l].acc);
        sp_q[l].rem <= 64'(prod) << 17;
        sp_q[l].res <= '0;
      end
    end
  end

  // square root chain
  assign sv[0] = sp_valid_q;
  assign sd[0] = sp_q;
  assign ss[SQRT_STEPS] = stall_i;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    plgc_sqrt_cell #(
      .STEP(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sv[i]),
      .stall_o(ss[i]),
      .data_i (sd[i]),
      .valid_o(sv[i+1]),
      .stall_i(ss[i+1]),
      .data_o (sd[i+1])
    );
  end

  assign valid_o = sv[SQRT_STEPS];
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      root_o[l] = sd[SQRT_STEPS][l].res[31:0];
    end
  end

  `PLGC_ASSERT_NEXT(a_accept_lands, clk_i, rst_ni, valid_i && !stall_o, s1_valid_q, "accepted item missing from first stage")
  `PLGC_ASSERT(a_root_max, clk_i, rst_ni, valid_o |-> ((root_o[LANE_L] <= 32'h8000_0000) && (root_o[LANE_R] <= 32'h8000_0000)), "root above one")

endmodule

>>> sim/pan_law_gain_checker.sv
`timescale 1ns / 100ps
module pan_law_gain_checker #(
  parameter int unsigned GAIN_FRAC_BITS = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               cmd_i,
  input  logic signed [15:0] pan_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [15:0]        gain_left_i,
  input  logic [15:0]        gain_right_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 gains_seen_o
);
  import plgc_pkg::*;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
  } gain_pair_t;

  localparam int DueDepth = 256;

  // ring of expected gains, written on input accept, read on output accept
  gain_pair_t gains_due [DueDepth];
  int         wr_cnt;
  int         rd_cnt;
  int         fail_count;
  int         gains_seen;

  assign fail_count_o = fail_count;
  assign pending_o    = wr_cnt - rd_cnt;
  assign gains_seen_o = gains_seen;

  // integer square root, floor
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // taper sqrt((1 - v) cos(v pi/2)) in fixed point
  function automatic logic [63:0] taper(input longint v);
    longint divs [7];
    longint theta, th2, acc, prod;
    logic [63:0] prd, r;
    divs = '{182, 132, 90, 56, 30, 12, 2};
    if (v < 0) v = 0;
    if (v > 32768) v = 32768;
    theta = (v * 64'sd1686629713 + 16384) >>> 15;
    th2   = (theta * theta + (64'sd1 << 29)) >>> 30;
    acc   = 64'sd1 << 30;
    for (int i = 0; i < 7; i++) begin
      prod = (th2 * acc + (64'sd1 << 29)) >>> 30;
      acc  = (64'sd1 << 30) - (prod + divs[i] / 2) / divs[i];
      if (acc < 0) acc = 0;
    end
    prd = 64'(32768 - v) * 64'(acc);
    r   = floor_sqrt(prd << 17);
    return (r + (64'd1 << (30 - GAIN_FRAC_BITS))) >> (31 - GAIN_FRAC_BITS);
  endfunction

  function automatic gain_pair_t pan_gains(input logic cmd, input logic signed [15:0] pan);
    longint     p;
    logic [63:0] one, gl, gr;
    gain_pair_t g;
    one = 64'd1 << GAIN_FRAC_BITS;
    p   = pan;
    if (p < -16384) p = -16384;
    if (p > 16384) p = 16384;
    if (cmd == CMD_MONO) begin
      gl = taper(p + 16384);
      gr = taper(32768 - (p + 16384));
    end else if (p > 0) begin
      gl = taper(2 * p);
      gr = one;
    end else if (p < 0) begin
      gl = one;
      gr = taper(-2 * p);
    end else begin
      gl = one;
      gr = one;
    end
    g.left  = gl[15:0];
    g.right = gr[15:0];
    return g;
  endfunction

  // predict on input accept, compare on output accept
  always @(posedge clk_i) begin
    gain_pair_t exp_g;
    if (!rst_ni) begin
      fail_count <= 0;
      gains_seen <= 0;
      wr_cnt     <= 0;
      rd_cnt     <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        gains_due[wr_cnt % DueDepth] <= pan_gains(cmd_i, pan_i);
        wr_cnt <= wr_cnt + 1;
      end
      if (out_valid_i && !out_stall_i) begin
        gains_seen <= gains_seen + 1;
        if (wr_cnt == rd_cnt) begin
          if (fail_count < 10) $display("unexpected item: left %0d right %0d",
                                        gain_left_i, gain_right_i);
          fail_count <= fail_count + 1;
        end else begin
          exp_g = gains_due[rd_cnt % DueDepth];
          rd_cnt <= rd_cnt + 1;
          if (exp_g.left !== gain_left_i || exp_g.right !== gain_right_i) begin
            if (fail_count < 10)
              $display("gain mismatch: expected left %0d right %0d, got left %0d right %0d",
                       exp_g.left, exp_g.right, gain_left_i, gain_right_i);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> sim/tb_pan_law_gain_calc.sv
`timescale 1ns / 100ps
module tb_pan_law_gain_calc;
  import plgc_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               cmd_i;
  logic signed [15:0] pan_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [15:0]        gain_left_o;
  logic [15:0]        gain_right_o;
  int                 fail_count;
  int                 pending;
  int                 gains_seen;
  int                 idle_pct;
  int                 stall_pct;
  int                 quiet_cycles;
  int                 items_sent;

  pan_law_gain_calc dut (.*);

  pan_law_gain_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .cmd_i, .pan_i,
    .out_valid_i(out_valid_o), .out_stall_i, .gain_left_i(gain_left_o),
    .gain_right_i(gain_right_o), .fail_count_o(fail_count), .pending_o(pending),
    .gains_seen_o(gains_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // random output stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // send one item, with random idle cycles ahead of it
  task automatic send_pan(input logic cmd, input logic signed [15:0] pan);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    pan_i      <= pan;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain_gains();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic signed [15:0] edge_pans [13];
    logic signed [15:0] pv;
    int                 sel;
    edge_pans = '{-16'sd32768, -16'sd16385, -16'sd16384, -16'sd16383, -16'sd1, 16'sd0,
                  16'sd1, 16'sd16383, 16'sd16384, 16'sd16385, 16'sd32767,
                  -16'sd8192, 16'sd8192};
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = 1'b0;
    pan_i       = '0;
    out_stall_i = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    quiet_cycles = 0;
    items_sent  = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: clamp edges, centre, both modes
    for (int i = 0; i < 13; i++) begin
      send_pan(CMD_MONO, edge_pans[i]);
      send_pan(CMD_BALANCE, edge_pans[i]);
    end
    // pause until all gains are back
    drain_gains();

    // random phases with varied idling and output stall
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < 232; n++) begin
        sel = $urandom_range(9);
        if (sel < 7) pv = 16'($signed($urandom_range(32768)) - 16384);
        else if (sel < 9) pv = 16'($urandom);
        else pv = edge_pans[$urandom_range(12)];
        send_pan(1'($urandom), pv);
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
    drain_gains();
    repeat (60) @(posedge clk_i);

    $display("sent %0d items in both pan modes, checked %0d gain pairs", items_sent,
             gains_seen);
    $display("covered clamped pans, centre, and four idle and stall mixes");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
